/* src/mhr_pkg.sv */
// Package for the MOS hex record decoder: field widths, character codes,
// parse phase encoding, the result record type and the hex digit decode function.
// Depends on nothing; used by mhr_parser and mos_hex_record_decoder.
package mhr_pkg;

	localparam int CHAR_W = 8;
	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;
	localparam int DPOS_W = 2;
	localparam int LCNT_W = 7;
	localparam int DIG_W  = 6;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_0       = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_9       = 8'd57;
	localparam logic [CHAR_W-1:0] CHAR_UA      = 8'd65;
	localparam logic [CHAR_W-1:0] CHAR_UZ      = 8'd90;
	localparam logic [CHAR_W-1:0] CHAR_LA      = 8'd97;
	localparam logic [CHAR_W-1:0] CHAR_LZ      = 8'd122;

	// Letters map to 10..35, so the offset is the letter base minus ten.
	localparam logic [CHAR_W-1:0] UPPER_OFS = 8'd55;
	localparam logic [CHAR_W-1:0] LOWER_OFS = 8'd87;

	localparam logic [DPOS_W-1:0] DPOS_FIRST  = 2'd0;
	localparam logic [DPOS_W-1:0] DPOS_SECOND = 2'd1;
	localparam logic [DPOS_W-1:0] DPOS_THIRD  = 2'd2;
	localparam logic [DPOS_W-1:0] DPOS_FOURTH = 2'd3;

	typedef enum logic [4:0] {
		PH_SKIP   = 5'b00001,
		PH_COUNT  = 5'b00010,
		PH_ADDR   = 5'b00100,
		PH_DATA   = 5'b01000,
		PH_IGNORE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              last;
	} result_t;

	// Value of one hex-like digit; anything that is not a digit or letter is zero.
	function automatic logic [DIG_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] v;
		begin
			v = '0;
			if (c >= CHAR_0 && c <= CHAR_9) begin
				v = c - CHAR_0;
			end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
				v = c - UPPER_OFS;
			end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
				v = c - LOWER_OFS;
			end
			digit_value = v[DIG_W-1:0];
		end
	endfunction

endpackage

/* src/mhr_parser.sv */
// Record parser: holds the line state and turns one character into at most
// one memory write request. Depends on mhr_pkg.
module mhr_parser
	import mhr_pkg::*;
#(
	parameter int LINE_LIMIT = 99
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CHAR_W-1:0] char_in,
	output result_t           res
);

	localparam logic [LCNT_W-1:0] LIMIT = LCNT_W'(LINE_LIMIT);

	phase_t              phase_q, phase_n;
	logic [DPOS_W-1:0]   dpos_q, dpos_n;
	logic [DATA_W-1:0]   hi_q, hi_n;
	logic [DATA_W-1:0]   remain_q, remain_n;
	logic [ADDR_W-1:0]   addr_q, addr_n;
	logic [LCNT_W-1:0]   lcnt_q, lcnt_n;

	logic [DIG_W-1:0]    dig;
	logic [DATA_W-1:0]   hi_digit;
	logic [DATA_W-1:0]   pair;

	assign dig      = digit_value(char_in);
	assign hi_digit = {dig[3:0], 4'b0000};
	assign pair     = hi_q + {{(DATA_W-DIG_W){1'b0}}, dig};

	always_comb begin
		phase_n  = phase_q;
		dpos_n   = dpos_q;
		hi_n     = hi_q;
		remain_n = remain_q;
		addr_n   = addr_q;
		lcnt_n   = lcnt_q;
		res      = '0;
		res.addr = addr_q;
		res.data = pair;
		res.last = (remain_q == 8'd1);

		if (char_in == CHAR_NEWLINE) begin
			// A newline ends the line and abandons any open record.
			phase_n = PH_SKIP;
			dpos_n  = DPOS_FIRST;
			hi_n    = '0;
			lcnt_n  = '0;
		end else begin
			case (phase_q)
				PH_SKIP: begin
					phase_n = PH_COUNT;
					dpos_n  = DPOS_FIRST;
				end
				PH_COUNT: begin
					if (dpos_q == DPOS_FIRST) begin
						hi_n   = hi_digit;
						dpos_n = DPOS_SECOND;
					end else begin
						remain_n = pair;
						dpos_n   = DPOS_FIRST;
						phase_n  = (pair == '0) ? PH_IGNORE : PH_ADDR;
					end
				end
				PH_ADDR: begin
					if (dpos_q == DPOS_FIRST || dpos_q == DPOS_THIRD) begin
						hi_n   = hi_digit;
						dpos_n = dpos_q + 2'd1;
					end else if (dpos_q == DPOS_SECOND) begin
						addr_n = {pair, addr_q[DATA_W-1:0]} & 16'hFF00;
						dpos_n = DPOS_THIRD;
					end else begin
						addr_n  = {addr_q[ADDR_W-1:DATA_W], pair};
						dpos_n  = DPOS_FIRST;
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					if (dpos_q == DPOS_FIRST) begin
						hi_n   = hi_digit;
						dpos_n = DPOS_SECOND;
					end else begin
						res.valid = 1'b1;
						addr_n    = addr_q + 16'd1;
						remain_n  = remain_q - 8'd1;
						dpos_n    = DPOS_FIRST;
						if (remain_q == 8'd1) begin
							phase_n = PH_IGNORE;
						end
					end
				end
				default: begin
				end
			endcase

			lcnt_n = lcnt_q + 7'd1;
			if (lcnt_n >= LIMIT) begin
				// Overlong line: start over as if a new line had begun.
				phase_n = PH_SKIP;
				dpos_n  = DPOS_FIRST;
				hi_n    = '0;
				lcnt_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP;
			dpos_q   <= DPOS_FIRST;
			hi_q     <= '0;
			remain_q <= '0;
			addr_q   <= '0;
			lcnt_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			dpos_q   <= dpos_n;
			hi_q     <= hi_n;
			remain_q <= remain_n;
			addr_q   <= addr_n;
			lcnt_q   <= lcnt_n;
		end
	end

`ifndef SYNTHESIS
	a_newline_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && char_in == CHAR_NEWLINE) |=> (phase_q == PH_SKIP && lcnt_q == '0))
		else $error("newline did not restart the line");

	a_line_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lcnt_q < LIMIT)
		else $error("line character count reached the limit");

	a_last_closes_record: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && res.last) |=> (phase_q == PH_IGNORE || phase_q == PH_SKIP))
		else $error("record still open after its last write");
`endif

endmodule

/* src/mos_hex_record_decoder.sv */
// Top level of the MOS hex record decoder: input register, record parser and
// output register on stream channels. Depends on mhr_pkg and mhr_parser.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+----------------------------------------
//   s_*     | in        | s_tvalid/s_tready | s_tdata[7:0] character
//   m_*     | out       | m_tvalid/m_tready | m_tdata address, data; m_tlast last byte
//
// A taken character waits in the input register, where the parser updates the line
// state, and its write is then loaded into the output register; one character is
// taken per cycle as long as the result side keeps up.
// A character that yields no write moves on even while the output register holds
// an untaken request; only a write waits for the output register to free up.
// Reset (arst_n low) empties both registers and puts the parser at a line start.
module mos_hex_record_decoder
	import mhr_pkg::*;
#(
	parameter int LINE_LIMIT = 99
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [CHAR_W-1:0]        s_tdata,   // [7:0] character
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [ADDR_W+DATA_W-1:0] m_tdata,   // [15:0] write_address, [23:16] write_data
	output logic                     m_tlast    // last_of_record
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              valid_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [DATA_W-1:0] data_s2;
	logic              last_s2;

	result_t           res;
	logic              out_free;
	logic              advance;

	// The character in the input register moves on when it gives no write, or
	// when the output register is empty or being emptied in this cycle.
	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && (!res.valid || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	mhr_parser #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.char_in (char_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			addr_s2 <= res.addr;
			data_s2 <= res.data;
			last_s2 <= res.last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {data_s2, addr_s2};
	assign m_tlast  = last_s2;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.valid) |-> out_free)
		else $error("write request loaded over an untaken request");

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("empty input register refused a character");

	a_held_without_write: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(char_s1)))
		else $error("stalled character lost from the input register");
`endif

endmodule
